/* design/kcs_pkg.sv */
package kcs_pkg;

  // fixed field widths
  localparam int CODE_W    = 16;
  localparam int BIN_IN_W  = 10;
  localparam int BIN_W     = 12;  // wide enough for any bin count in range
  localparam int CNT_W     = 12;
  localparam int POP_W     = 17;
  localparam int KLEN_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 12;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_LIMIT   = 2'd1;

  // register reset values
  localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd8;
  localparam logic [CNT_W-1:0]  SAT_RESET  = 12'd2500;

  // operation codes
  localparam logic FUNC_COUNT = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // command queue
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QFILL_W = 2;

  typedef struct packed {
    logic              func;
    logic [CODE_W-1:0] code;  // already masked to 2K bits
    logic [BIN_W-1:0]  bin;   // already clamped to the last bin
  } kcs_op_t;

  typedef struct packed {
    logic    valid;
    kcs_op_t op;
  } kcs_head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } kcs_stat_t;

endpackage

/* design/kcs_front.sv */
module kcs_front import kcs_pkg::*; #(
  parameter int MAX_K     = 8,
  parameter int HIST_BINS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                func,
  input  logic [CODE_W-1:0]   kmer_code,
  input  logic [BIN_IN_W-1:0] bin_index,
  input  logic [KLEN_W-1:0]   kmer_length,
  input  kcs_stat_t           stat,
  output kcs_head_t           head,
  output logic                busy
);

  kcs_op_t             q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QFILL_W-1:0]  fill;
  logic                push;
  logic [KLEN_W-1:0]   k_eff;
  logic [31:0]         mask;
  logic [BIN_W:0]      bin_ext;
  kcs_op_t             op_in;

  assign busy = stat.clearing || (fill == QFILL_W'(QDEPTH));
  assign push = start && !busy;

  // classify: mask the code to 2K bits, clamp the bin
  always_comb begin
    k_eff   = (kmer_length > KLEN_W'(MAX_K)) ? KLEN_W'(MAX_K) : kmer_length;
    mask    = (32'd1 << {k_eff, 1'b0}) - 32'd1;
    bin_ext = (BIN_W+1)'(bin_index);
    op_in.func = func;
    op_in.code = kmer_code & mask[CODE_W-1:0];
    if (bin_ext >= (BIN_W+1)'(HIST_BINS)) begin
      op_in.bin = BIN_W'(HIST_BINS - 1);
    end else begin
      op_in.bin = bin_ext[BIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (stat.pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !stat.pop) begin
        fill <= fill + 1'b1;
      end else if (!push && stat.pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assign head.valid = (fill != '0);
  assign head.op    = q[rd_ptr];

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= QFILL_W'(QDEPTH)) else $error("queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    stat.pop |-> fill != '0) else $error("pop from empty queue");

endmodule

/* design/kcs_back.sv */
module kcs_back import kcs_pkg::*; #(
  parameter int MAX_K     = 8,
  parameter int HIST_BINS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] saturation_limit,
  input  kcs_head_t        head,
  output kcs_stat_t        stat,
  output logic             done,
  output logic [POP_W-1:0] bin_population
);

  localparam int TW      = 2 * MAX_K;
  localparam int TDEPTH  = 1 << TW;
  localparam int BW      = $clog2(HIST_BINS);
  localparam int CLR_LEN = (TDEPTH > HIST_BINS) ? TDEPTH : HIST_BINS;
  localparam int CW      = $clog2(CLR_LEN);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CNT   = 3'd2;
  localparam logic [2:0] ST_DEC   = 3'd3;
  localparam logic [2:0] ST_INC   = 3'd4;
  localparam logic [2:0] ST_QRY   = 3'd5;

  logic [CNT_W-1:0] count_mem [TDEPTH];
  logic [POP_W-1:0] spec_mem  [HIST_BINS];

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CW-1:0]    clr;
  logic [TW-1:0]    cur_code;
  logic [BW-1:0]    cur_bin;
  logic [BW-1:0]    ob;
  logic [BW-1:0]    nb;

  logic             cnt_we;
  logic [TW-1:0]    cnt_wa;
  logic [CNT_W-1:0] cnt_wd;
  logic [TW-1:0]    cnt_ra;
  logic [CNT_W-1:0] cnt_rdata;
  logic             spc_we;
  logic [BW-1:0]    spc_wa;
  logic [POP_W-1:0] spc_wd;
  logic [BW-1:0]    spc_ra;
  logic [POP_W-1:0] spc_rdata;

  logic [CNT_W-1:0] now_cnt;
  logic [BW-1:0]    ob_c;
  logic [BW-1:0]    nb_c;
  logic             pop;

  function automatic logic [BW-1:0] bin_of(input logic [CNT_W-1:0] c);
    logic [CNT_W:0] cx;
    cx = {1'b0, c};
    if (cx >= (CNT_W+1)'(HIST_BINS - 1)) begin
      return BW'(HIST_BINS - 1);
    end
    return BW'(c);
  endfunction

  assign now_cnt = cnt_rdata + 1'b1;
  assign ob_c    = bin_of(cnt_rdata);
  assign nb_c    = bin_of(now_cnt);
  assign pop     = (state == ST_IDLE) && head.valid;
  assign cnt_ra  = TW'(head.op.code);

  always_comb begin
    state_next = state;
    cnt_we = 1'b0;
    cnt_wa = cur_code;
    cnt_wd = now_cnt;
    spc_we = 1'b0;
    spc_wa = nb;
    spc_wd = spc_rdata + 1'b1;
    spc_ra = nb;
    case (state)
      ST_CLEAR: begin
        cnt_we = ({1'b0, clr} < (CW+1)'(TDEPTH));
        cnt_wa = clr[TW-1:0];
        cnt_wd = '0;
        spc_we = ({1'b0, clr} < (CW+1)'(HIST_BINS));
        spc_wa = clr[BW-1:0];
        spc_wd = '0;
        if (clr == CW'(CLR_LEN - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        spc_ra = BW'(head.op.bin);
        if (head.valid) begin
          state_next = (head.op.func == FUNC_QUERY) ? ST_QRY : ST_CNT;
        end
      end
      ST_CNT: begin
        if (cnt_rdata >= saturation_limit) begin
          state_next = ST_IDLE;
        end else begin
          cnt_we = 1'b1;
          if (cnt_rdata != '0 && ob_c == nb_c) begin
            state_next = ST_IDLE;
          end else if (cnt_rdata != '0) begin
            spc_ra     = ob_c;
            state_next = ST_DEC;
          end else begin
            spc_ra     = nb_c;
            state_next = ST_INC;
          end
        end
      end
      ST_DEC: begin
        spc_we     = 1'b1;
        spc_wa     = ob;
        spc_wd     = spc_rdata - 1'b1;
        spc_ra     = nb;
        state_next = ST_INC;
      end
      ST_INC: begin
        spc_we     = 1'b1;
        state_next = ST_IDLE;
      end
      ST_QRY: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // counter table and spectrum, one write and one registered read each
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rdata <= count_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (spc_we) begin
      spec_mem[spc_wa] <= spc_wd;
    end
    spc_rdata <= spec_mem[spc_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr <= clr + 1'b1;
      end
      done <= (state == ST_QRY);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_code <= cnt_ra;
      cur_bin  <= BW'(head.op.bin);
    end
    if (state == ST_CNT) begin
      ob <= ob_c;
      nb <= nb_c;
    end
    if (state == ST_QRY) begin
      bin_population <= (cur_bin == '0) ? '0 : spc_rdata;
    end
  end

  assign stat.pop      = pop;
  assign stat.clearing = (state == ST_CLEAR);

  a_done_after_query: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_QRY) else $error("result without query");
  a_inc_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_INC |-> $past(state) == ST_CNT || $past(state) == ST_DEC)
    else $error("spectrum increment out of sequence");
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    (cnt_we && state == ST_CNT) |-> cnt_wd <= saturation_limit)
    else $error("counter written past limit");
  a_bins_differ: assert property (@(posedge clk) disable iff (rst)
    state == ST_DEC |-> ob != nb) else $error("decrement into same bin");

endmodule

/* design/kmer_count_spectrum.sv */
// channel   direction  handshake               word
// command   in         start, taken when !busy func, kmer_code, bin_index
// result    out        done, one-cycle strobe  bin_population
// config    in         cfg_we, no wait         cfg_index, cfg_wdata
//
// a count word takes the back end through a counter read (ST_CNT), then
// up to two read-modify-writes on the spectrum memory (one read, one write port)
// a query word takes the back end through ST_QRY; done is registered from that state and rises in the cycle after it
// a two-word queue lets the front take words while the back end is working
// after reset a clearing pass over max(4^MAX_K, HIST_BINS) addresses (65536 at
// the defaults) zeroes both memories; busy stays high throughout
// the receiver cannot stall: each result is shown for exactly one cycle
module kmer_count_spectrum import kcs_pkg::*; #(
  parameter int MAX_K     = 8,
  parameter int HIST_BINS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 func,
  input  logic [CODE_W-1:0]    kmer_code,
  input  logic [BIN_IN_W-1:0]  bin_index,
  output logic                 done,
  output logic [POP_W-1:0]     bin_population,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [KLEN_W-1:0] kmer_length;
  logic [CNT_W-1:0]  saturation_limit;
  kcs_head_t         head;
  kcs_stat_t         stat;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length      <= KLEN_RESET;
      saturation_limit <= SAT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KMER_LENGTH: kmer_length      <= cfg_wdata[KLEN_W-1:0];
        REG_SAT_LIMIT:   saturation_limit <= cfg_wdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: accept, mask the code, clamp the bin, queue the word
  kcs_front #(
    .MAX_K     (MAX_K),
    .HIST_BINS (HIST_BINS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .func        (func),
    .kmer_code   (kmer_code),
    .bin_index   (bin_index),
    .kmer_length (kmer_length),
    .stat        (stat),
    .head        (head),
    .busy        (busy)
  );

  // back: counter table, spectrum and the clearing pass
  kcs_back #(
    .MAX_K     (MAX_K),
    .HIST_BINS (HIST_BINS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .saturation_limit (saturation_limit),
    .head             (head),
    .stat             (stat),
    .done             (done),
    .bin_population   (bin_population)
  );

endmodule

/* tb/kmer_count_spectrum_tb.sv */
`timescale 1ns / 100ps

module kmer_count_spectrum_tb;
  import kcs_pkg::*;

  // model sizes, matching the block's default parameters
  localparam int LEN_MAX       = 8;
  localparam int TALLY_DEPTH   = 1 << (2 * LEN_MAX);
  localparam int SPECTRUM_BINS = 1024;
  localparam int LAST_BIN      = SPECTRUM_BINS - 1;

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // a count word can sit in the two-word queue, then take a counter read and up to two
  // spectrum updates, so this covers any word still in flight once the results are in
  localparam int DRAIN_CYCLES = 24;
  // covers the clearing pass plus over a thousand words
  localparam int CYCLE_LIMIT  = 400000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 func;
  logic [CODE_W-1:0]    kmer_code;
  logic [BIN_IN_W-1:0]  bin_index;
  logic                 done;
  logic [POP_W-1:0]     bin_population;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // one row of the directed table; a typed row carries its own expected population
  typedef struct {
    logic              op;
    logic [CODE_W-1:0] code;
    logic [9:0]        bin;
    bit                typed;
    logic [POP_W-1:0]  pop;
  } stim_row_t;

  // shadow of the block: per-code counters, count spectrum and both registers
  logic [CNT_W-1:0]  kmer_tally [TALLY_DEPTH];
  logic [POP_W-1:0]  spectrum [SPECTRUM_BINS];
  logic [KLEN_W-1:0] klen_shadow;
  logic [CNT_W-1:0]  sat_shadow;

  // populations still owed by the block, oldest first
  logic [POP_W-1:0]  pop_expected [$];

  int cycles;
  int errors;

  // reset config throughout; typed rows are read straight off the counts so far
  stim_row_t directed_words [18] = '{
    '{FUNC_QUERY, 16'hFFFF, 10'd0,    1'b1, 17'd0},  // empty spectrum, bin zero
    '{FUNC_QUERY, 16'h0000, 10'd1,    1'b1, 17'd0},
    '{FUNC_QUERY, 16'hA5A5, 10'd1023, 1'b1, 17'd0},  // last bin, empty
    '{FUNC_COUNT, 16'h0000, 10'd1023, 1'b0, 17'd0},  // lowest code
    '{FUNC_COUNT, 16'hFFFF, 10'd0,    1'b0, 17'd0},  // highest code, three times over
    '{FUNC_COUNT, 16'hFFFF, 10'd512,  1'b0, 17'd0},
    '{FUNC_COUNT, 16'hFFFF, 10'd1,    1'b0, 17'd0},
    '{FUNC_COUNT, 16'hA5A5, 10'd0,    1'b0, 17'd0},
    '{FUNC_QUERY, 16'h0000, 10'd1,    1'b1, 17'd2},
    '{FUNC_QUERY, 16'hFFFF, 10'd3,    1'b1, 17'd1},
    '{FUNC_QUERY, 16'h0000, 10'd2,    1'b1, 17'd0},  // code moved on from bin 2
    '{FUNC_QUERY, 16'hFFFF, 10'd0,    1'b1, 17'd0},  // bin zero stays zero
    '{FUNC_COUNT, 16'h5A5A, 10'd3,    1'b0, 17'd0},  // same code back to back
    '{FUNC_COUNT, 16'h5A5A, 10'd3,    1'b0, 17'd0},
    '{FUNC_COUNT, 16'h5A5A, 10'd3,    1'b0, 17'd0},
    '{FUNC_QUERY, 16'h5A5A, 10'd3,    1'b0, 17'd0},
    '{FUNC_QUERY, 16'h1234, 10'd1023, 1'b1, 17'd0},
    '{FUNC_QUERY, 16'h0000, 10'd512,  1'b1, 17'd0}
  };

  kmer_count_spectrum dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .kmer_code      (kmer_code),
    .bin_index      (bin_index),
    .done           (done),
    .bin_population (bin_population),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // counts at or past the last bin all land in it
  function automatic int unsigned bin_of(int unsigned count);
    return (count >= LAST_BIN) ? LAST_BIN : count;
  endfunction

  task automatic clear_shadow();
    foreach (kmer_tally[i]) kmer_tally[i] = '0;
    foreach (spectrum[i]) spectrum[i] = '0;
    klen_shadow = KLEN_RESET;
    sat_shadow  = SAT_RESET;
  endtask

  // one occurrence of a code: bump its counter unless saturated, move it between bins
  task automatic tally_kmer(logic [CODE_W-1:0] code);
    int unsigned len;
    int unsigned slot;
    int unsigned was;
    int unsigned now;
    int unsigned old_bin;
    int unsigned new_bin;
    len  = (klen_shadow > LEN_MAX) ? LEN_MAX : klen_shadow;
    slot = code & ((32'd1 << (2 * len)) - 32'd1);
    was  = kmer_tally[slot];
    if (was < sat_shadow) begin
      now              = was + 1;
      kmer_tally[slot] = now[CNT_W-1:0];
      new_bin          = bin_of(now);
      old_bin          = bin_of(was);
      if (was == 0) begin
        spectrum[new_bin] = spectrum[new_bin] + 1'b1;
      end else if (old_bin != new_bin) begin
        spectrum[old_bin] = spectrum[old_bin] - 1'b1;
        spectrum[new_bin] = spectrum[new_bin] + 1'b1;
      end
    end
  endtask

  function automatic logic [POP_W-1:0] population_of(logic [9:0] bin);
    return (bin == 0) ? '0 : spectrum[bin];
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= 50) $display("cycle %0d: %s", cycles, what);
  endtask

  // plain register write; dropping cfg_we before returning keeps it to one update per step
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == REG_KMER_LENGTH) klen_shadow = data[KLEN_W-1:0];
    else if (idx == REG_SAT_LIMIT) sat_shadow = data;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // kmer length goes in with junk above its four bits, which the block must drop
  task automatic set_kmer_length(int unsigned len);
    write_reg(REG_KMER_LENGTH, {8'($urandom), 4'(len)});
  endtask

  // present one word, optionally after a gap; the word is taken at the first edge
  // that sees busy low, and the shadow is brought up to date at that same edge
  task automatic send_word(logic op, logic [CODE_W-1:0] code, logic [9:0] bin,
                           int idle_pct, bit typed, logic [POP_W-1:0] typed_pop);
    int gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    func      <= op;
    kmer_code <= code;
    bin_index <= bin;
    do @(posedge clk); while (busy);
    if (op == FUNC_QUERY) pop_expected = {pop_expected, typed ? typed_pop : population_of(bin)};
    else tally_kmer(code);
  endtask

  // stop sending until every owed population is in, then let count words retire
  task automatic drain();
    start <= 1'b0;
    while (pop_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random words: most codes come from a small pool so counts climb and bins move;
  // queries lean on the low bins where the populations live, with the last bin
  // and the full range mixed in
  task automatic random_phase(int n_words, int idle_pct, int pause_at);
    logic [CODE_W-1:0] pool [16];
    logic              op;
    logic [CODE_W-1:0] code;
    logic [9:0]        bin;
    int                pick;
    foreach (pool[i]) pool[i] = 16'($urandom);
    for (int n = 0; n < n_words; n++) begin
      if (n == pause_at) drain();
      op   = ($urandom_range(0, 99) < 30) ? FUNC_QUERY : FUNC_COUNT;
      code = ($urandom_range(0, 99) < 60) ? pool[$urandom_range(0, 15)] : 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 55) bin = 10'($urandom_range(0, 12));
      else if (pick < 65) bin = 10'(LAST_BIN);
      else bin = 10'($urandom_range(0, LAST_BIN));
      send_word(op, code, bin, idle_pct, 1'b0, '0);
    end
    drain();
  endtask

  // with a zero length every code folds onto slot 0, so one counter runs up past
  // the last bin and into a limit just above it; every 32nd word is a query
  task automatic hammer_phase(int n_words, int idle_pct);
    logic [9:0] bin;
    for (int n = 0; n < n_words; n++) begin
      if (n % 32 == 31) begin
        bin = ($urandom_range(0, 1) != 0) ? 10'($urandom_range(1015, LAST_BIN))
                                          : 10'($urandom_range(0, 3));
        send_word(FUNC_QUERY, 16'($urandom), bin, idle_pct, 1'b0, '0);
      end else begin
        send_word(FUNC_COUNT, 16'($urandom), 10'($urandom), idle_pct, 1'b0, '0);
      end
    end
    drain();
  endtask

  // free-running cycle count and the watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // every done strobe must match the oldest owed population
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pop_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result word, population %0d", bin_population));
      end else if (bin_population !== pop_expected[0]) begin
        report_mismatch($sformatf("population %0d, expected %0d",
                                  bin_population, pop_expected[0]));
        void'(pop_expected.pop_front());
      end else begin
        void'(pop_expected.pop_front());
      end
    end
  end

  initial begin
    cycles    = 0;
    errors    = 0;
    rst       = 1'b1;
    start     = 1'b0;
    func      = FUNC_COUNT;
    kmer_code = '0;
    bin_index = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_KMER_LENGTH;
    cfg_wdata = '0;
    clear_shadow();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // the clearing pass holds busy high; stay off until it ends
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed table at the reset settings, no gaps
    foreach (directed_words[i])
      send_word(directed_words[i].op, directed_words[i].code, directed_words[i].bin, 0,
                directed_words[i].typed, directed_words[i].pop);
    drain();

    // full length, highest limit, back to back
    set_kmer_length(LEN_MAX);
    write_reg(REG_SAT_LIMIT, 12'd4095);
    random_phase(60, 0, -1);

    // two-base codes and a low limit: sixteen slots saturate quickly;
    // half way through the sender waits for every result
    set_kmer_length(2);
    write_reg(REG_SAT_LIMIT, 12'd5);
    random_phase(60, 45, 30);

    // length above the maximum acts as the maximum; limit of one sits under
    // counts already held, and nothing held is cleared by the length change
    set_kmer_length(15);
    write_reg(REG_SAT_LIMIT, 12'd1);
    random_phase(30, 11, -1);

    // zero length folds every code to slot 0; drive it into the last bin and
    // on to a limit a little above it
    set_kmer_length(0);
    write_reg(REG_SAT_LIMIT, 12'd1030);
    hammer_phase(1080, 11);

    // spare indexes are ignored; a zero limit blocks all counting
    write_reg(REG_SPARE_2, 12'($urandom));
    write_reg(REG_SPARE_3, 12'($urandom));
    set_kmer_length(1);
    write_reg(REG_SAT_LIMIT, 12'd0);
    random_phase(25, 45, -1);

    // back to the reset limit at a middling length
    set_kmer_length(4);
    write_reg(REG_SAT_LIMIT, SAT_RESET);
    write_reg(REG_SPARE_2, 12'($urandom));
    random_phase(40, 0, -1);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* kmer_count_spectrum.f */
design/kcs_pkg.sv
design/kcs_front.sv
design/kcs_back.sv
design/kmer_count_spectrum.sv
tb/kmer_count_spectrum_tb.sv
